### rtl/rrvn_pkg.sv
// Package for the robust range value normalizer.
// Holds sizes, register indexes and mode codes; no dependencies.
`default_nettype none
package rrvn_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int VAL_W     = 32;
  localparam int SHADE_W   = 17;
  localparam int FRAC_W    = 16;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [SHADE_W-1:0] ONE_Q16 = SHADE_W'(1 << FRAC_W);

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_COLOR_MODE = 2'd0;
  localparam logic [1:0] REG_RANGE_MODE = 2'd1;
  localparam logic [1:0] REG_FIXED_LOW  = 2'd2;
  localparam logic [1:0] REG_FIXED_HIGH = 2'd3;

  // color modes
  localparam logic [1:0] MODE_FLAT   = 2'd0;
  localparam logic [1:0] MODE_WEIGHT = 2'd1;
  localparam logic [1:0] MODE_AMPL   = 2'd2;

  // range modes
  localparam logic [1:0] RANGE_FIXED  = 2'd0;
  localparam logic [1:0] RANGE_SPAN   = 2'd1;
  localparam logic [1:0] RANGE_MEDIAN = 2'd2;

endpackage
`default_nettype wire

### rtl/rrvn_in_if.sv
// Input channel of the normalizer: valid/ready plus one item.
// Depends on rrvn_pkg.
`default_nettype none
interface rrvn_in_if;
  import rrvn_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] weight;
  logic [VAL_W-1:0] amplitude;
  logic             enabled;
  logic             valid_req;
  logic             last_in;

  modport source (output valid, weight, amplitude, enabled, valid_req, last_in,
                  input ready);
  modport sink   (input valid, weight, amplitude, enabled, valid_req, last_in,
                  output ready);
endinterface
`default_nettype wire

### rtl/rrvn_out_if.sv
// Result channel of the normalizer: valid/ready plus one result.
// Depends on rrvn_pkg.
`default_nettype none
interface rrvn_out_if;
  import rrvn_pkg::*;
  logic               valid;
  logic               ready;
  logic [SHADE_W-1:0] shade;
  logic               invalid;
  logic [VAL_W-1:0]   range_low;
  logic [VAL_W-1:0]   range_high;
  logic               last_out;

  modport source (output valid, shade, invalid, range_low, range_high, last_out,
                  input ready);
  modport sink   (input valid, shade, invalid, range_low, range_high, last_out,
                  output ready);
endinterface
`default_nettype wire

### rtl/robust_range_value_normalizer.sv
// Normalizer: one item per cycle while loading; after the final item it scans
// the store, in median mode ranks candidates by counting passes, then gives each
// enabled item through read, capture, prepare, 17-step shared divider and transfer
// (flat-mode and invalid items go from capture straight to transfer); a disabled one is skipped.
// Reset (synchronous, rst_n low) clears the sequencer, item count and registers.
// Depends on rrvn_pkg, rrvn_in_if and rrvn_out_if.
`default_nettype none
module robust_range_value_normalizer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rrvn_in_if.sink                            in_chan,
  rrvn_out_if.source                         out_chan,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rrvn_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [rrvn_pkg::PDATA_W-1:0]  pwdata,
  output logic      [rrvn_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready
);
  import rrvn_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_FSCAN, S_RANGE, S_CRD, S_CCAP, S_CSCAN, S_CEND, S_CLAMP,
    S_EMSTART, S_EMRD, S_EMCAP, S_EMPRE, S_EMDIV, S_EMOUT
  } state_t;

  function automatic logic [VAL_W-1:0] abs_diff(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
    logic signed [VAL_W:0] d;
    d = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
    abs_diff = d[VAL_W] ? VAL_W'(-d) : d[VAL_W-1:0];
  endfunction

  // item store
  logic [VAL_W-1:0] value_mem [MAX_ITEMS];
  logic [1:0]       flag_mem  [MAX_ITEMS];
  logic [VAL_W-1:0] rdv_r;
  logic [1:0]       rdf_r;
  logic [ADDR_W-1:0] rd_addr;

  state_t            state_r;
  logic [CNT_W-1:0]  cnt_r, j_r, i_r, less_r, le_r;
  logic              pend_r, any_en_r, sel_dev_r;
  logic [ADDR_W-1:0] last_en_r;
  logic [VAL_W-1:0]  mn_r, mx_r, cand_r, med_r, dev_r, lo_r, hi_r;
  logic [1:0]        color_r, range_r;
  logic [VAL_W-1:0]  fixed_low_r, fixed_high_r;
  logic [VAL_W:0]    num_r, rem_r;
  logic [VAL_W-1:0]  den_r;
  logic [FRAC_W-1:0] q_r;
  logic [4:0]        step_r;
  logic [SHADE_W-1:0] shade_r;
  logic              invalid_r, last_r;

  logic              in_xfer, out_xfer, cfg_wr, issue;
  logic [CNT_W-1:0]  k;
  logic [VAL_W-1:0]  key;
  logic              key_lt, key_le;
  logic [VAL_W:0]    rem2;
  logic signed [VAL_W+1:0] clamp_a, clamp_b;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign issue    = (j_r < cnt_r);
  assign k        = cnt_r >> 1;

  assign in_chan.ready       = (state_r == S_LOAD);
  assign out_chan.valid      = (state_r == S_EMOUT);
  assign out_chan.shade      = shade_r;
  assign out_chan.invalid    = invalid_r;
  assign out_chan.range_low  = lo_r;
  assign out_chan.range_high = hi_r;
  assign out_chan.last_out   = last_r;
  assign pready              = 1'b1;

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_COLOR_MODE: prdata = PDATA_W'(color_r);
      REG_RANGE_MODE: prdata = PDATA_W'(range_r);
      REG_FIXED_LOW:  prdata = fixed_low_r;
      default:        prdata = fixed_high_r;
    endcase
  end

  // select the store address
  always_comb begin
    case (state_r)
      S_CRD, S_EMRD: rd_addr = i_r[ADDR_W-1:0];
      default:       rd_addr = j_r[ADDR_W-1:0];
    endcase
  end

  // compare key for the selection passes
  always_comb begin
    key = sel_dev_r ? abs_diff(rdv_r, med_r) : rdv_r;
    if (sel_dev_r) begin
      key_lt = key < cand_r;
    end else begin
      key_lt = $signed(key) < $signed(cand_r);
    end
    key_le = key_lt || (key == cand_r);
  end

  assign rem2    = {rem_r[VAL_W-1:0], 1'b0};
  assign clamp_a = $signed({{2{med_r[VAL_W-1]}}, med_r}) - $signed({2'b00, dev_r});
  assign clamp_b = $signed({{2{med_r[VAL_W-1]}}, med_r}) + $signed({2'b00, dev_r});

  // store write and registered read
  always_ff @(posedge clk) begin
    if (in_xfer && (cnt_r < CNT_W'(MAX_ITEMS))) begin
      value_mem[cnt_r[ADDR_W-1:0]] <= (color_r == MODE_WEIGHT) ? in_chan.weight
                                                                : in_chan.amplitude;
      flag_mem[cnt_r[ADDR_W-1:0]]  <= {in_chan.valid_req, in_chan.enabled};
    end
    rdv_r <= value_mem[rd_addr];
    rdf_r <= flag_mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_LOAD;
      cnt_r        <= '0;
      j_r          <= '0;
      i_r          <= '0;
      pend_r       <= 1'b0;
      color_r      <= '0;
      range_r      <= '0;
      fixed_low_r  <= '0;
      fixed_high_r <= VAL_W'(1 << FRAC_W);
      lo_r         <= '0;
      hi_r         <= '0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (cfg_wr) begin
            case (paddr[3:2])
              REG_COLOR_MODE: color_r      <= pwdata[1:0];
              REG_RANGE_MODE: range_r      <= pwdata[1:0];
              REG_FIXED_LOW:  fixed_low_r  <= pwdata;
              default:        fixed_high_r <= pwdata;
            endcase
          end
          if (in_xfer) begin
            if (cnt_r < CNT_W'(MAX_ITEMS)) begin
              cnt_r <= cnt_r + 1'b1;
            end
            if (in_chan.last_in) begin
              j_r      <= '0;
              pend_r   <= 1'b0;
              any_en_r <= 1'b0;
              mn_r     <= {1'b0, {(VAL_W-1){1'b1}}};
              mx_r     <= {1'b1, {(VAL_W-1){1'b0}}};
              state_r  <= S_FSCAN;
            end
          end
        end

        // min, max and last enabled item
        S_FSCAN: begin
          if (issue) begin
            j_r <= j_r + 1'b1;
          end
          pend_r <= issue;
          if (pend_r) begin
            if ($signed(rdv_r) < $signed(mn_r)) mn_r <= rdv_r;
            if ($signed(rdv_r) > $signed(mx_r)) mx_r <= rdv_r;
            if (rdf_r[0]) begin
              any_en_r  <= 1'b1;
              last_en_r <= ADDR_W'(j_r - 1'b1);
            end
          end
          if (!issue && !pend_r) begin
            state_r <= S_RANGE;
          end
        end

        S_RANGE: begin
          if (color_r == MODE_FLAT) begin
            lo_r    <= fixed_low_r;
            hi_r    <= fixed_high_r;
            state_r <= S_EMSTART;
          end else begin
            case (range_r)
              RANGE_SPAN: begin
                lo_r         <= mn_r;
                hi_r         <= mx_r;
                fixed_low_r  <= mn_r;
                fixed_high_r <= mx_r;
                state_r      <= S_EMSTART;
              end
              RANGE_MEDIAN: begin
                sel_dev_r <= 1'b0;
                i_r       <= '0;
                state_r   <= S_CRD;
              end
              default: begin
                lo_r    <= fixed_low_r;
                hi_r    <= fixed_high_r;
                state_r <= S_EMSTART;
              end
            endcase
          end
        end

        S_CRD: state_r <= S_CCAP;

        S_CCAP: begin
          cand_r  <= sel_dev_r ? abs_diff(rdv_r, med_r) : rdv_r;
          j_r     <= '0;
          pend_r  <= 1'b0;
          less_r  <= '0;
          le_r    <= '0;
          state_r <= S_CSCAN;
        end

        // rank the candidate against every stored item
        S_CSCAN: begin
          if (issue) begin
            j_r <= j_r + 1'b1;
          end
          pend_r <= issue;
          if (pend_r) begin
            less_r <= less_r + CNT_W'(key_lt);
            le_r   <= le_r + CNT_W'(key_le);
          end
          if (!issue && !pend_r) begin
            state_r <= S_CEND;
          end
        end

        S_CEND: begin
          if ((less_r <= k) && (k < le_r)) begin
            if (!sel_dev_r) begin
              med_r     <= cand_r;
              sel_dev_r <= 1'b1;
              i_r       <= '0;
              state_r   <= S_CRD;
            end else begin
              dev_r   <= cand_r;
              state_r <= S_CLAMP;
            end
          end else begin
            i_r     <= i_r + 1'b1;
            state_r <= S_CRD;
          end
        end

        // clamp median +/- deviation to the data range
        S_CLAMP: begin
          if (clamp_a < $signed({{2{mn_r[VAL_W-1]}}, mn_r})) begin
            lo_r        <= mn_r;
            fixed_low_r <= mn_r;
          end else begin
            lo_r        <= clamp_a[VAL_W-1:0];
            fixed_low_r <= clamp_a[VAL_W-1:0];
          end
          if (clamp_b > $signed({{2{mx_r[VAL_W-1]}}, mx_r})) begin
            hi_r         <= mx_r;
            fixed_high_r <= mx_r;
          end else begin
            hi_r         <= clamp_b[VAL_W-1:0];
            fixed_high_r <= clamp_b[VAL_W-1:0];
          end
          state_r <= S_EMSTART;
        end

        S_EMSTART: begin
          i_r <= '0;
          if (any_en_r) begin
            state_r <= S_EMRD;
          end else begin
            cnt_r   <= '0;
            state_r <= S_LOAD;
          end
        end

        S_EMRD: state_r <= S_EMCAP;

        S_EMCAP: begin
          last_r    <= (i_r[ADDR_W-1:0] == last_en_r);
          invalid_r <= !rdf_r[1];
          num_r     <= VAL_W'(0) + ($signed({rdv_r[VAL_W-1], rdv_r})
                                    - $signed({lo_r[VAL_W-1], lo_r}));
          rem_r     <= $signed({hi_r[VAL_W-1], hi_r}) - $signed({lo_r[VAL_W-1], lo_r});
          if (!rdf_r[0]) begin
            i_r     <= i_r + 1'b1;
            state_r <= S_EMRD;
          end else if (!rdf_r[1]) begin
            shade_r <= '0;
            state_r <= S_EMOUT;
          end else if (color_r == MODE_FLAT) begin
            shade_r <= ONE_Q16;
            state_r <= S_EMOUT;
          end else begin
            state_r <= S_EMPRE;
          end
        end

        // fold signs and settle the easy cases (rem_r holds the span here)
        S_EMPRE: begin
          if (rem_r == '0) begin
            shade_r <= num_r[VAL_W] ? '0 : ONE_Q16;
            state_r <= S_EMOUT;
          end else begin
            if (rem_r[VAL_W]) begin
              num_r <= -num_r;
              den_r <= VAL_W'(-rem_r);
            end else begin
              den_r <= rem_r[VAL_W-1:0];
            end
            state_r <= S_EMDIV;
            step_r  <= 5'd0;
          end
        end

        // step 0 checks bounds, then 16 restoring division steps
        S_EMDIV: begin
          if (step_r == 5'd0) begin
            if (num_r[VAL_W] || (num_r == '0)) begin
              shade_r <= '0;
              state_r <= S_EMOUT;
            end else if (num_r >= {1'b0, den_r}) begin
              shade_r <= ONE_Q16;
              state_r <= S_EMOUT;
            end else begin
              rem_r  <= num_r;
              q_r    <= '0;
              step_r <= 5'd1;
            end
          end else begin
            if (rem2 >= {1'b0, den_r}) begin
              rem_r <= rem2 - {1'b0, den_r};
              q_r   <= {q_r[FRAC_W-2:0], 1'b1};
            end else begin
              rem_r <= rem2;
              q_r   <= {q_r[FRAC_W-2:0], 1'b0};
            end
            if (step_r == 5'(FRAC_W)) begin
              shade_r <= {1'b0, q_r[FRAC_W-2:0], (rem2 >= {1'b0, den_r})};
              state_r <= S_EMOUT;
            end else begin
              step_r <= step_r + 1'b1;
            end
          end
        end

        // hold the result until transfer
        S_EMOUT: begin
          if (out_xfer) begin
            if (last_r) begin
              cnt_r   <= '0;
              state_r <= S_LOAD;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_EMRD;
            end
          end
        end

        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule
`default_nettype wire

### dv/tb_robust_range_value_normalizer.sv
// Testbench for the robust range value normalizer: drives data sets with random
// gaps and stalls, predicts each shade and range, and checks every result transfer.
// Depends on rrvn_pkg, rrvn_in_if, rrvn_out_if and the normalizer RTL.
`default_nettype none

typedef struct {
  logic [16:0] shade;
  logic        invalid;
  logic [31:0] range_low;
  logic [31:0] range_high;
  logic        last_out;
} shade_result_t;

class shade_scoreboard;
  logic [1:0]  color_mode;
  logic [1:0]  range_mode;
  logic signed [31:0] fixed_low;
  logic signed [31:0] fixed_high;
  logic signed [31:0] values[64];
  logic [1:0]  flags[64];
  int          count;
  shade_result_t pending[$];
  int          errors;

  function new();
    color_mode = rrvn_pkg::MODE_FLAT;
    range_mode = rrvn_pkg::RANGE_FIXED;
    fixed_low  = 0;
    fixed_high = 32'sd65536;
    count = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      rrvn_pkg::REG_COLOR_MODE: color_mode = val[1:0];
      rrvn_pkg::REG_RANGE_MODE: range_mode = val[1:0];
      rrvn_pkg::REG_FIXED_LOW:  fixed_low  = val;
      default:                  fixed_high = val;
    endcase
  endfunction

  function logic [16:0] shade_of(logic signed [31:0] v, logic signed [31:0] lo,
                                 logic signed [31:0] hi);
    longint num, den;
    num = longint'(v) - longint'(lo);
    den = longint'(hi) - longint'(lo);
    if (den == 0) return (num >= 0) ? 17'h10000 : 17'h0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return 17'h0;
    if (num >= den) return 17'h10000;
    return 17'((num <<< 16) / den);
  endfunction

  // Sort ascending; signed compare on 64-bit keys.
  function automatic void sort_keys(ref longint a[64], input int n);
    longint k;
    int j;
    for (int i = 1; i < n; i++) begin
      k = a[i];
      j = i;
      while (j > 0 && a[j-1] > k) begin
        a[j] = a[j-1];
        j--;
      end
      a[j] = k;
    end
  endfunction

  function void pick_range(output logic signed [31:0] lo, output logic signed [31:0] hi);
    longint s[64], dv[64];
    longint med, d, a, b;
    lo = fixed_low;
    hi = fixed_high;
    if (range_mode == rrvn_pkg::RANGE_SPAN) begin
      lo = values[0];
      hi = values[0];
      for (int i = 1; i < count; i++) begin
        if (values[i] < lo) lo = values[i];
        if (values[i] > hi) hi = values[i];
      end
    end else if (range_mode == rrvn_pkg::RANGE_MEDIAN) begin
      for (int i = 0; i < count; i++) s[i] = longint'(values[i]);
      sort_keys(s, count);
      med = s[count/2];
      for (int i = 0; i < count; i++) dv[i] = (s[i] > med) ? s[i] - med : med - s[i];
      sort_keys(dv, count);
      d = dv[count/2];
      a = med - d;
      b = med + d;
      if (a < s[0]) a = s[0];
      if (b > s[count-1]) b = s[count-1];
      lo = 32'(a);
      hi = 32'(b);
    end
  endfunction

  // Note one accepted input item; at the final item queue the run's results.
  function void note_item(logic [31:0] w, logic [31:0] amp, logic en, logic va, logic last);
    logic signed [31:0] lo, hi;
    shade_result_t r;
    bit uniform;
    int first;
    if (count < 64) begin
      values[count] = (color_mode == rrvn_pkg::MODE_WEIGHT) ? w : amp;
      flags[count]  = {va, en};
      count++;
    end
    if (!last) return;
    uniform = (color_mode == rrvn_pkg::MODE_FLAT);
    if (uniform) begin
      lo = fixed_low;
      hi = fixed_high;
    end else begin
      pick_range(lo, hi);
      fixed_low = lo;
      fixed_high = hi;
    end
    first = pending.size();
    for (int i = 0; i < count; i++) begin
      if (!flags[i][0]) continue;
      r.invalid = !flags[i][1];
      r.shade = r.invalid ? 17'h0 : (uniform ? 17'h10000 : shade_of(values[i], lo, hi));
      r.range_low = lo;
      r.range_high = hi;
      r.last_out = 1'b0;
      pending = {pending, r};
    end
    if (pending.size() > first) pending[pending.size()-1].last_out = 1'b1;
    count = 0;
  endfunction

  task report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  task check_result(shade_result_t got);
    shade_result_t w;
    if (pending.size() == 0) begin
      report("unexpected result shade", 64'(got.shade), 64'd0);
      return;
    end
    w = pending.pop_front();
    if (got.shade !== w.shade) report("shade", 64'(got.shade), 64'(w.shade));
    if (got.invalid !== w.invalid) report("invalid", 64'(got.invalid), 64'(w.invalid));
    if (got.range_low !== w.range_low)
      report("range_low", 64'(got.range_low), 64'(w.range_low));
    if (got.range_high !== w.range_high)
      report("range_high", 64'(got.range_high), 64'(w.range_high));
    if (got.last_out !== w.last_out)
      report("last_out", 64'(got.last_out), 64'(w.last_out));
  endtask
endclass

module tb_robust_range_value_normalizer;
  import rrvn_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  int   hold_off = 0;
  bit   stim_done = 0;
  shade_scoreboard sb;

  rrvn_in_if  in_chan();
  rrvn_out_if out_chan();

  robust_range_value_normalizer i_dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  initial begin
    in_chan.valid = 1'b0;
    in_chan.weight = '0;
    in_chan.amplitude = '0;
    in_chan.enabled = 1'b0;
    in_chan.valid_req = 1'b0;
    in_chan.last_in = 1'b0;
    out_chan.ready = 1'b0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
  endfunction

  // Check each result transfer at the rising edge.
  always @(posedge clk) begin
    shade_result_t r;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      r.shade = out_chan.shade;
      r.invalid = out_chan.invalid;
      r.range_low = out_chan.range_low;
      r.range_high = out_chan.range_high;
      r.last_out = out_chan.last_out;
      sb.check_result(r);
    end
  end

  // Receiver: random stalls, or a long hold-off when requested.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 9) < 7) || stim_done;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  // Offer one item; valid stays high on return, so the next item or drain drops it.
  task automatic send_item(logic [31:0] w, logic [31:0] amp, logic en, logic va,
                           logic last, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_chan.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.weight <= w;
    in_chan.amplitude <= amp;
    in_chan.enabled <= en;
    in_chan.valid_req <= va;
    in_chan.last_in <= last;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_item(w, amp, en, va, last);
    @(negedge clk);
  endtask

  // Wait for every expected result and an idle block, then settle before a write.
  task automatic drain();
    in_chan.valid <= 1'b0;
    while (sb.pending.size() != 0 || !in_chan.ready) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_val(int kind);
    case (kind)
      0: return $urandom();
      1: return 32'(int'($urandom_range(0, 400000)) - 200000);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(0, 8)) << 14;
    endcase
  endfunction

  task automatic random_set(int n, bit no_gap);
    int kind;
    kind = $urandom_range(0, 3);
    for (int i = 0; i < n; i++)
      send_item(rand_val(kind), rand_val(kind), $urandom_range(0, 5) != 0,
                $urandom_range(0, 7) != 0, i == n - 1, no_gap);
  endtask

  initial begin
    int sent;
    bit pressed;
    sb = new();
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: uniform mode with reset range, invalid item, field extremes.
    send_item(32'h7fffffff, 32'h80000000, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(32'h80000000, 32'h7fffffff, 1'b1, 1'b0, 1'b0, 1'b0);
    send_item(32'h0, 32'hffffffff, 1'b0, 1'b1, 1'b1, 1'b0);
    drain();
    // Weight, fixed reversed range, zero range.
    write_reg(REG_COLOR_MODE, 32'(MODE_WEIGHT));
    write_reg(REG_RANGE_MODE, 32'(RANGE_FIXED));
    write_reg(REG_FIXED_LOW, 32'h0002_0000);
    write_reg(REG_FIXED_HIGH, 32'h0000_0000);
    send_item(32'h0001_0000, 32'h0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(32'h0003_0000, 32'h0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(32'hffff_0000, 32'h0, 1'b1, 1'b1, 1'b1, 1'b0);
    drain();
    write_reg(REG_FIXED_LOW, 32'h0001_0000);
    write_reg(REG_FIXED_HIGH, 32'h0001_0000);
    send_item(32'h0001_0000, 32'h0, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(32'h0000_ffff, 32'h0, 1'b1, 1'b1, 1'b1, 1'b0);
    drain();
    // Amplitude min/max extremes, unknown color mode, no enabled item.
    write_reg(REG_COLOR_MODE, 32'd3);
    write_reg(REG_RANGE_MODE, 32'(RANGE_SPAN));
    send_item(32'h0, 32'h80000000, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(32'h0, 32'h7fffffff, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(32'h0, 32'h00000005, 1'b1, 1'b1, 1'b1, 1'b0);
    send_item(32'h0, 32'h5, 1'b0, 1'b1, 1'b1, 1'b0);
    drain();
    // Median mode, and unknown range mode acting as fixed.
    write_reg(REG_COLOR_MODE, 32'(MODE_AMPL));
    write_reg(REG_RANGE_MODE, 32'(RANGE_MEDIAN));
    send_item(32'h0, 32'h0000_1000, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(32'h0, 32'h0005_0000, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(32'h0, 32'hfff0_0000, 1'b1, 1'b1, 1'b0, 1'b0);
    send_item(32'h0, 32'h0000_2000, 1'b1, 1'b1, 1'b1, 1'b0);
    drain();
    write_reg(REG_RANGE_MODE, 32'd3);
    send_item(32'h0, 32'h0000_8000, 1'b1, 1'b1, 1'b1, 1'b0);
    drain();
    // Overfull set: items past the store limit are dropped.
    write_reg(REG_RANGE_MODE, 32'(RANGE_SPAN));
    random_set(70, 0);
    drain();

    // Random phases with varying settings; mostly small sets.
    sent = 0;
    pressed = 0;
    while (sent < 150) begin
      int n;
      write_reg(REG_COLOR_MODE, $urandom_range(0, 3));
      write_reg(REG_RANGE_MODE, $urandom_range(0, 3));
      write_reg(REG_FIXED_LOW, rand_val($urandom_range(0, 3)));
      write_reg(REG_FIXED_HIGH, rand_val($urandom_range(0, 3)));
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
      if (!pressed && sent >= 60) begin
        pressed = 1;
        hold_off = 3000;
        random_set(64, 1);
        random_set(n, 1);
        sent += 64;
      end else begin
        random_set(n, 0);
      end
      sent += n;
      drain();
    end
    stim_done = 1;
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #40000000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire
